// ===== sv/rgbkf_pkg.sv =====
// Shared types and constants of the RGB 3x3 kernel filter.
package rgbkf_pkg;

   localparam int MAX_WIDTH_DEF = 2048;
   localparam int PIX_W         = 24;
   localparam int LINE_W        = 2 * PIX_W;
   localparam int CHAN_W        = 8;
   localparam int FW_W          = 12;
   localparam int FH_W          = 13;
   localparam int SELC_W        = 12;
   localparam int SELR_W        = 13;
   localparam int ROW_W         = 13;
   localparam int KIND_W        = 2;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 13;
   localparam int OUT_DEPTH     = 8;

   // floor(s / 9) == (s * BOX_RECIP) >> BOX_SHIFT for every 9-pixel sum s
   localparam int BOX_RECIP     = 3641;
   localparam int BOX_SHIFT     = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEL_LEFT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEL_RIGHT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEL_TOP      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SEL_BOTTOM   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_KIND  = 3'd6;

   typedef enum logic [KIND_W-1:0] {
      KIND_EDGE    = 2'd0,
      KIND_SHARPEN = 2'd1,
      KIND_BOX     = 2'd2,
      KIND_GAUSS   = 2'd3
   } kind_type;

   typedef struct packed {
      logic interior;
      logic frame_end;
   } meta_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              frame_end;
   } rsp_type;

endpackage

// ===== sv/rgbkf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rgbkf_ram #(
   parameter int WIDTH = rgbkf_pkg::LINE_W,
   parameter int DEPTH = rgbkf_pkg::MAX_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rgbkf_kernel.sv =====
// Two-stage kernel datapath: neighbor sums per channel, then kernel and clamp.
module rgbkf_kernel (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   input  logic [8:0][rgbkf_pkg::PIX_W-1:0]            win,
   input  rgbkf_pkg::meta_type                         meta,
   input  rgbkf_pkg::kind_type                         kind,
   output logic                                        out_valid,
   output rgbkf_pkg::rsp_type                          out_data
);

   localparam int CW = rgbkf_pkg::CHAN_W;

   logic                       valid_ff;
   rgbkf_pkg::meta_type        meta_ff;
   logic [9:0]                 corn_in  [3];
   logic [9:0]                 edg_in   [3];
   logic [CW-1:0]              ctr_in   [3];
   logic [11:0]                tot_in   [3];
   logic [9:0]                 corn_ff  [3];
   logic [9:0]                 edg_ff   [3];
   logic [CW-1:0]              ctr_ff   [3];
   logic [11:0]                tot_ff   [3];
   logic [CW-1:0]              res      [3];

   function automatic logic [CW-1:0] apply_kernel(
      input rgbkf_pkg::kind_type k,
      input logic [9:0]          corn,
      input logic [9:0]          edg,
      input logic [CW-1:0]       ctr,
      input logic [11:0]         tot
   );
      logic signed [13:0] val;
      logic [23:0]        prod;
      logic [13:0]        gsum;
      prod = 24'(tot) * 24'(rgbkf_pkg::BOX_RECIP);
      gsum = {4'b0, corn} + {3'b0, edg, 1'b0} + {4'b0, ctr, 2'b0};
      unique case (k)
         rgbkf_pkg::KIND_EDGE: begin
            val = $signed({3'b0, ctr, 3'b0}) - $signed({4'b0, corn})
                  - $signed({4'b0, edg});
         end
         rgbkf_pkg::KIND_SHARPEN: begin
            val = $signed({4'b0, ctr, 2'b0}) + $signed({6'b0, ctr})
                  - $signed({4'b0, edg});
         end
         rgbkf_pkg::KIND_BOX: begin
            val = $signed({1'b0, 13'(prod >> rgbkf_pkg::BOX_SHIFT)});
         end
         rgbkf_pkg::KIND_GAUSS: begin
            val = $signed({4'b0, gsum[13:4]});
         end
      endcase
      if (val < 0) begin
         return '0;
      end else if (val > 14'sd255) begin
         return '1;
      end
      return val[CW-1:0];
   endfunction

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         corn_in[ch] = 10'(win[0][rgbkf_pkg::PIX_W-1-CW*ch -: CW])
                     + 10'(win[2][rgbkf_pkg::PIX_W-1-CW*ch -: CW])
                     + 10'(win[6][rgbkf_pkg::PIX_W-1-CW*ch -: CW])
                     + 10'(win[8][rgbkf_pkg::PIX_W-1-CW*ch -: CW]);
         edg_in[ch]  = 10'(win[1][rgbkf_pkg::PIX_W-1-CW*ch -: CW])
                     + 10'(win[3][rgbkf_pkg::PIX_W-1-CW*ch -: CW])
                     + 10'(win[5][rgbkf_pkg::PIX_W-1-CW*ch -: CW])
                     + 10'(win[7][rgbkf_pkg::PIX_W-1-CW*ch -: CW]);
         ctr_in[ch]  = win[4][rgbkf_pkg::PIX_W-1-CW*ch -: CW];
         tot_in[ch]  = 12'(corn_in[ch]) + 12'(edg_in[ch]) + 12'(ctr_in[ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      meta_ff <= meta;
      for (int ch = 0; ch < 3; ch++) begin
         corn_ff[ch] <= corn_in[ch];
         edg_ff[ch]  <= edg_in[ch];
         ctr_ff[ch]  <= ctr_in[ch];
         tot_ff[ch]  <= tot_in[ch];
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         res[ch] = meta_ff.interior
                 ? apply_kernel(kind, corn_ff[ch], edg_ff[ch], ctr_ff[ch], tot_ff[ch])
                 : ctr_ff[ch];
      end
   end

   assign out_valid          = valid_ff;
   assign out_data.red       = res[0];
   assign out_data.green     = res[1];
   assign out_data.blue      = res[2];
   assign out_data.frame_end = meta_ff.frame_end;

endmodule

// ===== sv/rgbkf_out_fifo.sv =====
// Result queue between the kernel datapath and the result channel.
module rgbkf_out_fifo #(
   parameter int DEPTH = rgbkf_pkg::OUT_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   input  rgbkf_pkg::rsp_type wr_data,
   output logic               rd_valid,
   input  logic               rd_ready,
   output rgbkf_pkg::rsp_type rd_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rgbkf_pkg::rsp_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pop;

   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (wr_valid && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!wr_valid && pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== sv/rgb_3x3_kernel_filter.sv =====
// Top level: raster RGB 3x3 kernel filter with line-store RAM and result queue.
// Throughput: one item per cycle while req_ready is high, which needs a free result
// queue slot; a pixel reads and writes the line-store RAM once, a drain at most reads it.
// Each result passes the line-store read, window, kernel sums and result queue in order.
// Reset: clears position, pending count and window at once, then sweeps the line-store RAM
// to zero; req_ready stays low during the sweep while configuration writes are still taken.
module rgb_3x3_kernel_filter #(
   parameter int MAX_WIDTH = rgbkf_pkg::MAX_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [rgbkf_pkg::CHAN_W-1:0]          req_in_red,
   input  logic [rgbkf_pkg::CHAN_W-1:0]          req_in_green,
   input  logic [rgbkf_pkg::CHAN_W-1:0]          req_in_blue,
   input  logic                                  req_drain,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rgbkf_pkg::CHAN_W-1:0]          rsp_out_red,
   output logic [rgbkf_pkg::CHAN_W-1:0]          rsp_out_green,
   output logic [rgbkf_pkg::CHAN_W-1:0]          rsp_out_blue,
   output logic                                  rsp_frame_end,
   input  logic                                  csr_wr_en,
   input  logic [rgbkf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rgbkf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
   localparam int PEND_W = $clog2(MAX_WIDTH + 3);
   localparam int ROW_W  = rgbkf_pkg::ROW_W;
   localparam int PIX_W  = rgbkf_pkg::PIX_W;
   // common width for all position and bound compares
   localparam int XW     = ((CNT_W > ROW_W) ? CNT_W : ROW_W) + 2;
   localparam int CRED_W = $clog2(rgbkf_pkg::OUT_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [rgbkf_pkg::FW_W-1:0]   frame_width_ff;
   logic [rgbkf_pkg::FH_W-1:0]   frame_height_ff;
   logic [rgbkf_pkg::SELC_W-1:0] sel_left_ff, sel_right_ff;
   logic [rgbkf_pkg::SELR_W-1:0] sel_top_ff, sel_bottom_ff;
   rgbkf_pkg::kind_type          filter_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= rgbkf_pkg::FW_W'(1);
         frame_height_ff <= rgbkf_pkg::FH_W'(1);
         sel_left_ff     <= '0;
         sel_right_ff    <= '0;
         sel_top_ff      <= '0;
         sel_bottom_ff   <= '0;
         filter_kind_ff  <= rgbkf_pkg::KIND_EDGE;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rgbkf_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[rgbkf_pkg::FW_W-1:0];
            rgbkf_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[rgbkf_pkg::FH_W-1:0];
            rgbkf_pkg::CSR_SEL_LEFT:     sel_left_ff     <= csr_wdata[rgbkf_pkg::SELC_W-1:0];
            rgbkf_pkg::CSR_SEL_RIGHT:    sel_right_ff    <= csr_wdata[rgbkf_pkg::SELC_W-1:0];
            rgbkf_pkg::CSR_SEL_TOP:      sel_top_ff      <= csr_wdata[rgbkf_pkg::SELR_W-1:0];
            rgbkf_pkg::CSR_SEL_BOTTOM:   sel_bottom_ff   <= csr_wdata[rgbkf_pkg::SELR_W-1:0];
            rgbkf_pkg::CSR_FILTER_KIND: begin
               filter_kind_ff <= rgbkf_pkg::kind_type'(csr_wdata[rgbkf_pkg::KIND_W-1:0]);
            end
            default: ;  // unused index: drop the write
         endcase
      end
   end

   // Effective frame size: a zero width or height acts as one, and the
   // width saturates at the line-store depth.
   logic [CNT_W-1:0] w_eff;
   logic [rgbkf_pkg::FH_W-1:0] h_eff;

   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = CNT_W'(1);
      end else if (XW'(frame_width_ff) > XW'(MAX_WIDTH)) begin
         w_eff = CNT_W'(MAX_WIDTH);
      end else begin
         w_eff = CNT_W'(frame_width_ff);
      end
      h_eff = (frame_height_ff == '0) ? rgbkf_pkg::FH_W'(1) : frame_height_ff;
   end

   // ---------------------------------------------------------------------
   // Clearing sweep of the line store after reset
   // ---------------------------------------------------------------------
   state_type        state_ff, state_in;
   logic [COL_W-1:0] clr_cnt_ff, clr_cnt_in;

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + COL_W'(1);
            if (clr_cnt_ff == COL_W'(MAX_WIDTH - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: ;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 0: accept, positions, pending count, line-store read
   // ---------------------------------------------------------------------
   logic [COL_W-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [CRED_W-1:0] cred_ff, cred_in;

   logic [COL_W-1:0]  ic, oc, ic_adv, oc_adv, rd_addr;
   logic [ROW_W-1:0]  ir, orow, ir_adv, or_adv;
   logic              ic_last, ir_last, oc_last, or_last;
   logic              accept, do_item, emit, pend_zero, pend_over;
   logic              pop;
   rgbkf_pkg::meta_type meta0;
   logic [PIX_W-1:0]  req_pix;

   assign accept  = req_valid && req_ready;
   assign pop     = rsp_valid && rsp_ready;
   assign req_pix = {req_in_red, req_in_green, req_in_blue};

   always_comb begin
      // restart any position that lies beyond a shrunk frame
      ic   = (XW'(in_col_ff)  >= XW'(w_eff)) ? '0 : in_col_ff;
      ir   = (XW'(in_row_ff)  >= XW'(h_eff)) ? '0 : in_row_ff;
      oc   = (XW'(out_col_ff) >= XW'(w_eff)) ? '0 : out_col_ff;
      orow = (XW'(out_row_ff) >= XW'(h_eff)) ? '0 : out_row_ff;

      ic_last = (XW'(ic) + XW'(1))   >= XW'(w_eff);
      ir_last = (XW'(ir) + XW'(1))   >= XW'(h_eff);
      oc_last = (XW'(oc) + XW'(1))   >= XW'(w_eff);
      or_last = (XW'(orow) + XW'(1)) >= XW'(h_eff);

      ic_adv = ic_last ? '0 : ic + COL_W'(1);
      ir_adv = ic_last ? (ir_last ? '0 : ir + ROW_W'(1)) : ir;
      oc_adv = oc_last ? '0 : oc + COL_W'(1);
      or_adv = oc_last ? (or_last ? '0 : orow + ROW_W'(1)) : orow;

      pend_zero = (pend_ff == '0);
      pend_over = XW'(pend_ff) > XW'(w_eff);

      // a drain with nothing pending is taken and dropped
      do_item = accept && (!req_drain || !pend_zero);
      emit    = accept && (req_drain ? !pend_zero : pend_over);

      // a drain reads the column one past the pixel being emitted
      rd_addr = req_drain ? oc_adv : ic;

      meta0.interior  = (XW'(orow) >= XW'(1))
                     && ((XW'(orow) + XW'(2)) <= XW'(h_eff))
                     && (XW'(oc) >= XW'(1))
                     && ((XW'(oc) + XW'(2)) <= XW'(w_eff))
                     && (XW'(orow) >= XW'(sel_top_ff))
                     && (XW'(orow) <  XW'(sel_bottom_ff))
                     && (XW'(oc) >= XW'(sel_left_ff))
                     && (XW'(oc) <  XW'(sel_right_ff));
      meta0.frame_end = ((XW'(orow) + XW'(1)) == XW'(h_eff))
                     && ((XW'(oc) + XW'(1)) == XW'(w_eff));

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pend_in    = pend_ff;
      // every accepted item keeps the restarted positions
      if (accept) begin
         in_col_in  = ic;
         in_row_in  = ir;
         out_col_in = oc;
         out_row_in = orow;
      end
      if (accept && !req_drain) begin
         in_col_in = ic_adv;
         in_row_in = ir_adv;
      end
      if (emit) begin
         out_col_in = oc_adv;
         out_row_in = or_adv;
      end
      // a pixel that emits leaves the pending count unchanged
      if (accept && !req_drain && !emit) begin
         pend_in = pend_ff + PEND_W'(1);
      end else if (accept && req_drain && emit) begin
         pend_in = pend_ff - PEND_W'(1);
      end

      // hold a queue slot for every result in flight
      cred_in = cred_ff;
      if (emit && !pop) begin
         cred_in = cred_ff + CRED_W'(1);
      end else if (!emit && pop) begin
         cred_in = cred_ff - CRED_W'(1);
      end
   end

   assign req_ready = (state_ff == ST_RUN) && (cred_ff < CRED_W'(rgbkf_pkg::OUT_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         pend_ff    <= '0;
         cred_ff    <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pend_ff    <= pend_in;
         cred_ff    <= cred_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: line-store data back, window shift, write-back
   // ---------------------------------------------------------------------
   logic                      s1_valid_ff, s1_write_ff, s1_emit_ff, s1_fwd_ff;
   logic [COL_W-1:0]          s1_addr_ff;
   logic [PIX_W-1:0]          s1_bot_ff;
   logic [rgbkf_pkg::LINE_W-1:0] s1_fwd_data_ff;
   rgbkf_pkg::meta_type       s1_meta_ff;

   logic [rgbkf_pkg::LINE_W-1:0] ram_rd_data, line_rd, ram_wr_data;
   logic [COL_W-1:0]          ram_wr_addr;
   logic                      ram_wr_en;
   logic [PIX_W-1:0]          line_top, line_mid;
   logic                      fwd_hit;

   logic [8:0][PIX_W-1:0]     win_ff, win_in;
   logic                      s2_valid_ff;
   rgbkf_pkg::meta_type       s2_meta_ff;

   // the RAM returns old data when read and written at once: forward the
   // word that the item ahead writes to the same column
   assign line_rd  = s1_fwd_ff ? s1_fwd_data_ff : ram_rd_data;
   assign line_top = line_rd[rgbkf_pkg::LINE_W-1:PIX_W];
   assign line_mid = line_rd[PIX_W-1:0];
   assign fwd_hit  = s1_valid_ff && s1_write_ff && (s1_addr_ff == rd_addr);

   // outside the clearing sweep, push the column up one row: the middle row moves to two-above
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = s1_valid_ff && s1_write_ff;
         ram_wr_addr = s1_addr_ff;
         ram_wr_data = {line_mid, s1_bot_ff};
      end
   end

   always_comb begin
      win_in = win_ff;
      if (s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_in[3*r]     = win_ff[3*r + 1];
            win_in[3*r + 1] = win_ff[3*r + 2];
         end
         win_in[2] = line_top;
         win_in[5] = line_mid;
         win_in[8] = s1_bot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         s1_valid_ff <= do_item;
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
         win_ff      <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_write_ff    <= !req_drain;
      s1_emit_ff     <= emit;
      s1_addr_ff     <= rd_addr;
      s1_bot_ff      <= req_drain ? '0 : req_pix;
      s1_meta_ff     <= meta0;
      s1_fwd_ff      <= fwd_hit;
      s1_fwd_data_ff <= {line_mid, s1_bot_ff};
      s2_meta_ff     <= s1_meta_ff;
   end

   rgbkf_ram #(
      .WIDTH (rgbkf_pkg::LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (do_item),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------
   // Stages 2 and 3: kernel arithmetic, then the result queue
   // ---------------------------------------------------------------------
   logic               krn_valid;
   rgbkf_pkg::rsp_type krn_data, out_data;

   rgbkf_kernel u_kernel (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .win       (win_ff),
      .meta      (s2_meta_ff),
      .kind      (filter_kind_ff),
      .out_valid (krn_valid),
      .out_data  (krn_data)
   );

   rgbkf_out_fifo #(
      .DEPTH (rgbkf_pkg::OUT_DEPTH)
   ) u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (krn_valid),
      .wr_data  (krn_data),
      .rd_valid (rsp_valid),
      .rd_ready (rsp_ready),
      .rd_data  (out_data)
   );

   assign rsp_out_red   = out_data.red;
   assign rsp_out_green = out_data.green;
   assign rsp_out_blue  = out_data.blue;
   assign rsp_frame_end = out_data.frame_end;

endmodule
